// ===== rtl/mrtb_pkg.sv =====
package mrtb_pkg;

  localparam int FuncW     = 2;
  localparam int GroupW    = 3;
  localparam int SlotW     = 3;
  localparam int ValW      = 16;
  localparam int RunW      = 31;
  localparam int NumStrobe = 6;
  localparam int PrescW    = 11;
  localparam int CfgW      = ValW + 1;
  localparam int StateW    = ValW + 1;
  localparam int InDataW   = 24;
  localparam int OutDataW  = 56;

  typedef enum logic [FuncW-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  // Group codes on the bus: down-counter groups below GRP_DELAY0, on-delay
  // groups from GRP_DELAY0 up to but not including GRP_NONE.
  localparam logic [GroupW-1:0] GRP_DELAY0 = 3'd3;
  localparam logic [GroupW-1:0] GRP_NONE   = 3'd6;

  // Rate lane of a group within its kind.
  localparam logic [1:0] LANE_FAST = 2'd0;
  localparam logic [1:0] LANE_MID  = 2'd1;
  localparam logic [1:0] LANE_SLOW = 2'd2;

  localparam int STB_10MS  = 0;
  localparam int STB_100MS = 2;
  localparam int STB_1S    = 4;

  localparam logic [RunW-1:0] RUN_LAST = 31'h7FFF_FFFE;

  localparam logic [PrescW-1:0] STROBE_PERIOD [NumStrobe] = '{
    11'd10, 11'd20, 11'd100, 11'd200, 11'd1000, 11'd2000
  };

  typedef struct packed {
    logic            en;
    logic [ValW-1:0] limit;
    logic [ValW-1:0] count;
    logic            done;
  } tmr_entry_t;

  typedef struct packed {
    logic is_delay;
    logic active;
  } step_op_t;

endpackage

// ===== rtl/mrtb_ram.sv =====
module mrtb_ram #(
  parameter int Width = 16,
  parameter int Depth = 24
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/mrtb_alu.sv =====
module mrtb_alu (
  input  mrtb_pkg::step_op_t   op_i,
  input  mrtb_pkg::tmr_entry_t ent_i,
  output mrtb_pkg::tmr_entry_t ent_o
);

  import mrtb_pkg::*;

  logic [ValW-1:0] step_sum;
  logic            at_limit;
  logic            nonzero;

  // One adder serves both kinds: plus one for on-delay timers, minus one for
  // down-counters.
  assign step_sum = ent_i.count + {{(ValW-1){~op_i.is_delay}}, 1'b1};
  assign at_limit = ent_i.count >= ent_i.limit;
  assign nonzero  = ent_i.count != '0;

  always_comb begin
    ent_o = ent_i;
    if (op_i.active) begin
      if (!op_i.is_delay) begin
        if (nonzero) begin
          ent_o.count = step_sum;
        end
      end else if (ent_i.en) begin
        if (at_limit) begin
          ent_o.done = 1'b1;
        end else begin
          ent_o.count = step_sum;
        end
      end else begin
        ent_o.count = '0;
        ent_o.done  = 1'b0;
      end
    end
  end

endmodule

// ===== rtl/multi_rate_timer_bank_core.sv =====
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: func; tdata: group, slot, value, enable
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: strobes, read value, done, elapsed
//
// For a tick, the single step unit visits each timer entry once, down-counters first
// and then on-delay timers; a load or write goes straight to ST_DONE, a read passes
// through ST_READ first. s_axis_tready is high only when idle.
// A finished result waits in the output register while the next item is accepted.
// Reset clears control state and per-entry valid bits; never-written entries read
// as zero, so no clearing pass runs after reset.
module multi_rate_timer_bank_core #(
  parameter int DOWN_PER_GROUP  = 8,
  parameter int DELAY_PER_GROUP = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [2:0] group, [5:3] slot, [21:6] load_value, [22] run_enable, [23] zero
  input  logic [mrtb_pkg::InDataW-1:0]      s_axis_tdata,
  // [1:0] func
  input  logic [mrtb_pkg::FuncW-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [5:0] strobes, [21:6] read_value, [22] done_res, [53:23] elapsed_ms, [55:54] zero
  output logic [mrtb_pkg::OutDataW-1:0]     m_axis_tdata
);

  import mrtb_pkg::*;

  localparam int NumDown  = 3 * DOWN_PER_GROUP;
  localparam int NumDelay = 3 * DELAY_PER_GROUP;
  localparam int DAW      = (NumDown > 1) ? $clog2(NumDown) : 1;
  localparam int LAW      = (NumDelay > 1) ? $clog2(NumDelay) : 1;
  localparam int MaxPer   = (DOWN_PER_GROUP > DELAY_PER_GROUP) ? DOWN_PER_GROUP
                                                               : DELAY_PER_GROUP;
  localparam int SCW      = (MaxPer > 1) ? $clog2(MaxPer) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ,
    ST_DONE
  } state_e;

  state_e state_q;

  // Input fields.
  func_e              in_func;
  logic [GroupW-1:0]  in_group;
  logic [SlotW-1:0]   in_slot;
  logic [ValW-1:0]    in_value;
  logic               in_en;
  logic               in_is_down;
  logic               in_is_delay;
  logic [DAW-1:0]     in_dk;
  logic [LAW-1:0]     in_lk;
  logic               acc;

  // Timebase.
  logic [RunW-1:0]    run_q;
  logic [RunW-1:0]    run_nxt;
  logic [PrescW-1:0]  presc_q   [NumStrobe];
  logic [PrescW-1:0]  presc_nxt [NumStrobe];
  logic [NumStrobe-1:0] strobe_q;
  logic [NumStrobe-1:0] strobe_nxt;

  // Sweep issue side.
  logic               sw_run_q;
  logic               sw_delay_q;
  logic [1:0]         sw_grp_q;
  logic [SCW-1:0]     sw_slot_q;
  logic [DAW-1:0]     sw_dadr_q;
  logic [LAW-1:0]     sw_ladr_q;
  logic               sw_last_slot;
  logic               sw_active;

  // Sweep write-back side.
  logic               wb_vld_q;
  step_op_t           wb_op_q;
  logic [DAW-1:0]     wb_dadr_q;
  logic [LAW-1:0]     wb_ladr_q;
  logic               wb_dvld_q;
  logic               wb_cvld_q;
  logic               wb_svld_q;
  tmr_entry_t         alu_in;
  tmr_entry_t         alu_out;

  // Entry valid bits.
  logic [NumDown-1:0]  dvld_q;
  logic [NumDelay-1:0] cvld_q;
  logic [NumDelay-1:0] svld_q;

  // RAM ports.
  logic               d_we;
  logic [DAW-1:0]     d_waddr;
  logic [ValW-1:0]    d_wdata;
  logic [DAW-1:0]     d_raddr;
  logic [ValW-1:0]    d_rdata;
  logic               c_we;
  logic [CfgW-1:0]    c_rdata;
  logic               s_we;
  logic [StateW-1:0]  s_rdata;
  logic [LAW-1:0]     l_raddr;

  // Read capture and result.
  logic               rd_down_q;
  logic               rd_delay_q;
  logic               rd_vld_q;
  logic [ValW-1:0]    rd_rval;
  logic               rd_done;
  logic [NumStrobe-1:0] res_strobe_q;
  logic [ValW-1:0]    res_rval_q;
  logic               res_done_q;

  // Output register.
  logic               m_valid_q;
  logic               out_load;
  logic [NumStrobe-1:0] out_strobe_q;
  logic [ValW-1:0]    out_rval_q;
  logic               out_done_q;
  logic [RunW-1:0]    out_elapsed_q;

  assign in_func     = func_e'(s_axis_tuser);
  assign in_group    = s_axis_tdata[2:0];
  assign in_slot     = s_axis_tdata[5:3];
  assign in_value    = s_axis_tdata[21:6];
  assign in_en       = s_axis_tdata[22];
  assign in_is_down  = (in_group < GRP_DELAY0) && (32'(in_slot) < 32'(DOWN_PER_GROUP));
  assign in_is_delay = (in_group >= GRP_DELAY0) && (in_group < GRP_NONE)
                       && (32'(in_slot) < 32'(DELAY_PER_GROUP));
  assign in_dk = DAW'(32'(in_group) * 32'(DOWN_PER_GROUP) + 32'(in_slot));
  assign in_lk = LAW'((32'(in_group) - 32'(GRP_DELAY0)) * 32'(DELAY_PER_GROUP)
                      + 32'(in_slot));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign run_nxt = (run_q == RUN_LAST) ? '0 : run_q + 1'b1;

  always_comb begin
    for (int p = 0; p < NumStrobe; p++) begin
      if (presc_q[p] == STROBE_PERIOD[p] - 1'b1) begin
        presc_nxt[p]  = '0;
        strobe_nxt[p] = 1'b1;
      end else begin
        presc_nxt[p]  = presc_q[p] + 1'b1;
        strobe_nxt[p] = 1'b0;
      end
    end
  end

  assign sw_last_slot = sw_delay_q ? (sw_slot_q == SCW'(DELAY_PER_GROUP - 1))
                                   : (sw_slot_q == SCW'(DOWN_PER_GROUP - 1));

  // The fast down-counter group steps on every tick; the others on their strobe.
  always_comb begin
    unique case (sw_grp_q)
      LANE_FAST: sw_active = sw_delay_q ? strobe_q[STB_10MS] : 1'b1;
      LANE_MID:  sw_active = strobe_q[STB_100MS];
      default:   sw_active = strobe_q[STB_1S];
    endcase
  end

  always_comb begin
    alu_in = '0;
    if (wb_op_q.is_delay) begin
      if (wb_cvld_q) begin
        alu_in.en    = c_rdata[ValW];
        alu_in.limit = c_rdata[ValW-1:0];
      end
      if (wb_svld_q) begin
        alu_in.count = s_rdata[StateW-1:1];
        alu_in.done  = s_rdata[0];
      end
    end else if (wb_dvld_q) begin
      alu_in.count = d_rdata;
    end
  end

  mrtb_alu u_alu (
    .op_i  (wb_op_q),
    .ent_i (alu_in),
    .ent_o (alu_out)
  );

  assign d_we    = (acc && in_func == FUNC_LOAD && in_is_down)
                || (wb_vld_q && wb_op_q.active && !wb_op_q.is_delay);
  assign d_waddr = (state_q == ST_SWEEP) ? wb_dadr_q : in_dk;
  assign d_wdata = (state_q == ST_SWEEP) ? alu_out.count : in_value;
  assign d_raddr = (state_q == ST_SWEEP) ? sw_dadr_q : in_dk;
  assign c_we    = acc && in_func == FUNC_WRITE && in_is_delay;
  assign s_we    = wb_vld_q && wb_op_q.active && wb_op_q.is_delay;
  assign l_raddr = (state_q == ST_SWEEP) ? sw_ladr_q : in_lk;

  assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  mrtb_ram #(.Width(ValW), .Depth(NumDown)) u_down_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  mrtb_ram #(.Width(CfgW), .Depth(NumDelay)) u_cfg_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (in_lk),
    .wdata_i ({in_en, in_value}),
    .raddr_i (l_raddr),
    .rdata_o (c_rdata)
  );

  mrtb_ram #(.Width(StateW), .Depth(NumDelay)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (wb_ladr_q),
    .wdata_i ({alu_out.count, alu_out.done}),
    .raddr_i (l_raddr),
    .rdata_o (s_rdata)
  );

  // A down-counter that was never loaded reads as zero and therefore as done.
  always_comb begin
    rd_rval = '0;
    rd_done = 1'b0;
    if (rd_down_q) begin
      rd_rval = rd_vld_q ? d_rdata : '0;
      rd_done = (rd_rval == '0);
    end else if (rd_delay_q && rd_vld_q) begin
      rd_rval = s_rdata[StateW-1:1];
      rd_done = s_rdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      run_q         <= '0;
      presc_q       <= '{default: '0};
      strobe_q      <= '0;
      sw_run_q      <= 1'b0;
      sw_delay_q    <= 1'b0;
      sw_grp_q      <= LANE_FAST;
      sw_slot_q     <= '0;
      sw_dadr_q     <= '0;
      sw_ladr_q     <= '0;
      wb_vld_q      <= 1'b0;
      wb_op_q       <= '0;
      wb_dadr_q     <= '0;
      wb_ladr_q     <= '0;
      wb_dvld_q     <= 1'b0;
      wb_cvld_q     <= 1'b0;
      wb_svld_q     <= 1'b0;
      dvld_q        <= '0;
      cvld_q        <= '0;
      svld_q        <= '0;
      rd_down_q     <= 1'b0;
      rd_delay_q    <= 1'b0;
      rd_vld_q      <= 1'b0;
      res_strobe_q  <= '0;
      res_rval_q    <= '0;
      res_done_q    <= 1'b0;
      m_valid_q     <= 1'b0;
      out_strobe_q  <= '0;
      out_rval_q    <= '0;
      out_done_q    <= 1'b0;
      out_elapsed_q <= '0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (d_we) begin
        dvld_q[d_waddr] <= 1'b1;
      end
      if (c_we) begin
        cvld_q[in_lk] <= 1'b1;
      end
      if (s_we) begin
        svld_q[wb_ladr_q] <= 1'b1;
      end
      wb_vld_q <= (state_q == ST_SWEEP) && sw_run_q;

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            unique case (in_func)
              FUNC_TICK: begin
                run_q      <= run_nxt;
                presc_q    <= presc_nxt;
                strobe_q   <= strobe_nxt;
                sw_run_q   <= 1'b1;
                sw_delay_q <= 1'b0;
                sw_grp_q   <= LANE_FAST;
                sw_slot_q  <= '0;
                sw_dadr_q  <= '0;
                sw_ladr_q  <= '0;
                state_q    <= ST_SWEEP;
              end
              FUNC_LOAD, FUNC_WRITE: begin
                res_strobe_q <= '0;
                res_rval_q   <= '0;
                res_done_q   <= 1'b0;
                state_q      <= ST_DONE;
              end
              FUNC_READ: begin
                rd_down_q  <= in_is_down;
                rd_delay_q <= in_is_delay;
                rd_vld_q   <= in_is_down ? dvld_q[in_dk] : svld_q[in_lk];
                state_q    <= ST_READ;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end

        ST_SWEEP: begin
          // Read of entry k is issued while entry k-1 is written back.
          wb_op_q.is_delay <= sw_delay_q;
          wb_op_q.active   <= sw_active;
          wb_dadr_q        <= sw_dadr_q;
          wb_ladr_q        <= sw_ladr_q;
          wb_dvld_q        <= dvld_q[sw_dadr_q];
          wb_cvld_q        <= cvld_q[sw_ladr_q];
          wb_svld_q        <= svld_q[sw_ladr_q];
          if (sw_run_q) begin
            if (sw_delay_q) begin
              sw_ladr_q <= sw_ladr_q + 1'b1;
            end else begin
              sw_dadr_q <= sw_dadr_q + 1'b1;
            end
            if (sw_last_slot) begin
              sw_slot_q <= '0;
              if (sw_grp_q == LANE_SLOW) begin
                sw_grp_q <= LANE_FAST;
                if (sw_delay_q) begin
                  sw_run_q <= 1'b0;
                end else begin
                  sw_delay_q <= 1'b1;
                end
              end else begin
                sw_grp_q <= sw_grp_q + 1'b1;
              end
            end else begin
              sw_slot_q <= sw_slot_q + 1'b1;
            end
          end else if (!wb_vld_q) begin
            res_strobe_q <= strobe_q;
            res_rval_q   <= '0;
            res_done_q   <= 1'b0;
            state_q      <= ST_DONE;
          end
        end

        ST_READ: begin
          res_strobe_q <= '0;
          res_rval_q   <= rd_rval;
          res_done_q   <= rd_done;
          state_q      <= ST_DONE;
        end

        ST_DONE: begin
          if (out_load) begin
            out_strobe_q  <= res_strobe_q;
            out_rval_q    <= res_rval_q;
            out_done_q    <= res_done_q;
            out_elapsed_q <= run_q;
            state_q       <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, out_elapsed_q, out_done_q, out_rval_q, out_strobe_q};

  // Issue and write-back of the down-counter sweep never meet at one address.
  a_sweep_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wb_vld_q && !wb_op_q.is_delay && sw_run_q && !sw_delay_q) |-> (wb_dadr_q != sw_dadr_q))
    else $error("sweep read and write-back hit the same down-counter entry");

  a_sweep_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sw_run_q || wb_vld_q) |-> (state_q == ST_SWEEP))
    else $error("sweep active outside the sweep state");

  a_run_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q != '1)
    else $error("run-time counter reached the wrap value");

  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_func == FUNC_READ) |=> (state_q == ST_READ) ##1 (state_q == ST_DONE))
    else $error("read item did not finish in two cycles");

  a_tick_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_func == FUNC_TICK) |=> (sw_run_q && sw_dadr_q == '0 && !sw_delay_q))
    else $error("tick did not start the sweep at the first entry");

endmodule
